[sv/lmr_pkg.sv]
// ----------------------------------------------------------------------------
// lmr_pkg
// Shared constants, function codes and command/status types for the LED
// matrix row frame generator.
// ----------------------------------------------------------------------------
package lmr_pkg;

  localparam int DEVICE_COUNT = 4;
  localparam int COL_COUNT    = DEVICE_COUNT * 8;
  localparam int DEV_W        = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int FRAME_W      = 16;
  localparam int WORD_W       = 64;
  localparam int SLOT_COUNT   = WORD_W / FRAME_W;
  localparam int ROW_W        = 6;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_SHIFT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_BCAST = 2'd3;

  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
    logic bcast;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_row;
  } status_t;

endpackage

[sv/lmr_ctrl.sv]
// ----------------------------------------------------------------------------
// lmr_ctrl
// Controller: accepts items, sequences the refresh walk and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module lmr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  logic [1:0]      func,
  output logic            result_valid,
  input  logic            result_ready,
  output lmr_pkg::cmd_t   cmd,
  input  lmr_pkg::status_t status
);
  import lmr_pkg::*;

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_REFRESH = 1'b1;

  logic state;
  logic state_next;
  logic result_valid_next;
  logic slot_free;
  logic accept;

  assign slot_free  = !result_valid || result_ready;
  assign item_ready = (state == ST_IDLE) && slot_free;
  assign accept     = item_valid && item_ready;

  always_comb begin
    cmd       = '0;
    cmd.emit  = (state == ST_REFRESH) && slot_free;
    if (accept) begin
      unique case (func)
        FUNC_LOAD:  cmd.load  = 1'b1;
        FUNC_SHIFT: cmd.shift = 1'b1;
        FUNC_CLEAR: cmd.clear = 1'b1;
        FUNC_BCAST: cmd.bcast = 1'b1;
        default:    cmd.bcast = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load || cmd.shift || cmd.clear) begin
          state_next = ST_REFRESH;
        end
      end
      ST_REFRESH: begin
        if (cmd.emit && status.last_row) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.emit || cmd.bcast) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

[sv/lmr_datapath.sv]
// ----------------------------------------------------------------------------
// lmr_datapath
// Datapath: column store, row counters, row transpose and the output
// register for chain words.
// ----------------------------------------------------------------------------
module lmr_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lmr_pkg::cmd_t               cmd,
  output lmr_pkg::status_t            status,
  input  logic [7:0]                  column_bits,
  input  logic [3:0]                  cmd_addr,
  input  logic [7:0]                  cmd_data,
  output logic [lmr_pkg::WORD_W-1:0]  chain_word,
  output logic [lmr_pkg::ROW_W-1:0]   row_number,
  output logic                        last
);
  import lmr_pkg::*;

  logic [7:0]         col [COL_COUNT];
  logic [2:0]         row_sel;
  logic [DEV_W-1:0]   dev;
  logic               dev_last;
  logic               start;
  logic [7:0]         row_byte;
  logic [FRAME_W-1:0] row_frame;
  logic [FRAME_W-1:0] bcast_frame;
  logic [WORD_W-1:0]  row_word;
  logic [WORD_W-1:0]  bcast_word;
  logic [ROW_W-1:0]   row_num;

  assign start           = cmd.load || cmd.shift || cmd.clear;
  assign dev_last        = (int'(dev) == DEVICE_COUNT - 1);
  assign status.last_row = dev_last && (row_sel == 3'd7);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      row_byte[7-k] = col[k][row_sel];
    end
  end

  assign row_frame   = {4'd0, 4'({1'b0, row_sel} + 4'd1), row_byte};
  assign bcast_frame = {4'd0, cmd_addr, cmd_data};
  assign row_num     = ROW_W'({dev, row_sel}) + ROW_W'(1);

  always_comb begin
    for (int p = 0; p < SLOT_COUNT; p++) begin
      row_word[p*FRAME_W +: FRAME_W]   = (p < DEVICE_COUNT && int'(dev) == p) ?
                                         row_frame : '0;
      bcast_word[p*FRAME_W +: FRAME_W] = (p < DEVICE_COUNT) ? bcast_frame : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COL_COUNT; i++) begin
        col[i] <= '0;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < COL_COUNT; i++) begin
        col[i] <= '0;
      end
    end else if (cmd.load) begin
      col[0] <= column_bits;
    end else if (cmd.shift) begin
      for (int i = 1; i < COL_COUNT; i++) begin
        col[i] <= col[i-1];
      end
      col[0] <= '0;
    end else if (cmd.emit && row_sel == 3'd7) begin
      // rotate the next device's columns into the low eight places
      for (int i = 0; i < COL_COUNT; i++) begin
        col[i] <= col[(i + 8) % COL_COUNT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sel <= '0;
      dev     <= '0;
    end else if (start) begin
      row_sel <= '0;
      dev     <= '0;
    end else if (cmd.emit) begin
      row_sel <= row_sel + 3'd1;
      if (row_sel == 3'd7) begin
        dev <= dev_last ? '0 : dev + DEV_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bcast) begin
      chain_word <= bcast_word;
      row_number <= '0;
      last       <= 1'b1;
    end else if (cmd.emit) begin
      chain_word <= row_word;
      row_number <= row_num;
      last       <= status.last_row;
    end
  end

endmodule

[sv/led_matrix_row_frame_generator.sv]
// ----------------------------------------------------------------------------
// led_matrix_row_frame_generator
// Column store and row frame generator for a chain of cascaded 8x8 LED
// matrix drivers.
// ----------------------------------------------------------------------------
// Load, shift and clear items update the column store in the accept cycle
// and then emit one chain word per display row, DEVICE_COUNT*8 beats with
// last on the final one; the walk produces at most one beat per cycle. A
// broadcast item produces a single beat with row_number 0. The next item
// is accepted once the final beat of the previous one sits in the output
// register and that register is free to reload.
module led_matrix_row_frame_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [1:0]                  func,
  input  logic [7:0]                  column_bits,
  input  logic [3:0]                  cmd_addr,
  input  logic [7:0]                  cmd_data,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [lmr_pkg::WORD_W-1:0]  chain_word,
  output logic [lmr_pkg::ROW_W-1:0]   row_number,
  output logic                        last
);
  import lmr_pkg::*;

  cmd_t    cmd;
  status_t status;

  lmr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  lmr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .column_bits (column_bits),
    .cmd_addr    (cmd_addr),
    .cmd_data    (cmd_data),
    .chain_word  (chain_word),
    .row_number  (row_number),
    .last        (last)
  );

endmodule

[verif/tb_led_matrix_row_frame_generator.sv]
// ----------------------------------------------------------------------------
// tb_led_matrix_row_frame_generator
// Self-checking testbench for the LED matrix row frame generator. A queue of
// load, shift, clear and broadcast items feeds a valid/ready driver. Every
// accepted item predicts its chain words; load, shift and clear items also
// update a local column store. A monitor checks each output beat against the
// oldest predicted beat while both sides stall at random outside a calm window.
// ----------------------------------------------------------------------------
module tb_led_matrix_row_frame_generator;
  import lmr_pkg::*;

  localparam int RANDOM_ITEMS = 289;
  localparam int IDLE_PCT     = 12;
  localparam int CALM_FROM    = 3000;
  localparam int CALM_TO      = 6000;
  localparam int DRAIN_CYCLES = COL_COUNT + 16;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] column_bits;
    logic [3:0] cmd_addr;
    logic [7:0] cmd_data;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] chain_word;
    logic [ROW_W-1:0]  row_number;
    logic              last;
  } beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  logic [1:0]        func = FUNC_LOAD;
  logic [7:0]        column_bits = '0;
  logic [3:0]        cmd_addr = '0;
  logic [7:0]        cmd_data = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [WORD_W-1:0] chain_word;
  logic [ROW_W-1:0]  row_number;
  logic              last;

  item_t      pending_items[$];
  beat_t      expected_beats[$];
  logic [7:0] columns [COL_COUNT];
  item_t      next_item;
  beat_t      oldest;
  logic       item_fire = 1'b0;
  logic       calm;
  int         cycle_count = 0;
  int         items_total = 0;
  int         items_taken = 0;
  int         beats_seen = 0;
  int         fail_count = 0;
  int         func_seen [4] = '{0, 0, 0, 0};

  led_matrix_row_frame_generator dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .column_bits  (column_bits),
    .cmd_addr     (cmd_addr),
    .cmd_data     (cmd_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .chain_word   (chain_word),
    .row_number   (row_number),
    .last         (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  task automatic queue_item(input logic [1:0] f, input logic [7:0] cb,
                            input logic [3:0] ca, input logic [7:0] cd);
    pending_items.push_back(item_t'{f, cb, ca, cd});
  endtask

  task automatic queue_random(input logic [1:0] f);
    queue_item(f, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
               8'($urandom_range(0, 255)));
  endtask

  // Append the chain words the item produces; non-broadcast items first update the column store.
  task automatic predict_frames(input item_t it);
    beat_t              b;
    logic [FRAME_W-1:0] frame;
    logic [7:0]         row_byte;
    int                 c, r, t, j, k, d;
    if (it.func == FUNC_BCAST) begin
      frame = {4'h0, it.cmd_addr, it.cmd_data};
      b.chain_word = '0;
      for (d = 0; d < DEVICE_COUNT; d++) b.chain_word[d*FRAME_W +: FRAME_W] = frame;
      b.row_number = '0;
      b.last = 1'b1;
      expected_beats.push_back(b);
    end else begin
      case (it.func)
        FUNC_LOAD: columns[0] = it.column_bits;
        FUNC_SHIFT: begin
          for (c = COL_COUNT - 1; c > 0; c--) columns[c] = columns[c-1];
          columns[0] = '0;
        end
        default: for (c = 0; c < COL_COUNT; c++) columns[c] = '0;
      endcase
      for (r = 1; r <= COL_COUNT; r++) begin
        t = (r - 1) / 8;
        j = (r - 1) % 8;
        for (k = 0; k < 8; k++) row_byte[7-k] = columns[8*t+k][j];
        frame = {8'(r - 8*t), row_byte};
        b.chain_word = '0;
        b.chain_word[t*FRAME_W +: FRAME_W] = frame;
        b.row_number = ROW_W'(r);
        b.last = (r == COL_COUNT);
        expected_beats.push_back(b);
      end
    end
  endtask

  task automatic note_failure(input string msg);
    if (fail_count < REPORT_MAX) $display("MISMATCH @%0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_fire <= 1'b0;
      for (int c = 0; c < COL_COUNT; c++) columns[c] = '0;
    end else begin
      cycle_count <= cycle_count + 1;
      item_fire <= item_valid && item_ready;
      if (item_valid && item_ready) begin
        predict_frames(item_t'{func, column_bits, cmd_addr, cmd_data});
        func_seen[func]++;
        items_taken++;
      end
      if (result_valid && result_ready) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          note_failure($sformatf("unexpected beat word=%h row=%0d last=%b",
                                 chain_word, row_number, last));
        end else begin
          oldest = expected_beats.pop_front();
          if (chain_word !== oldest.chain_word || row_number !== oldest.row_number ||
              last !== oldest.last)
            note_failure($sformatf("exp word=%h row=%0d last=%b, got word=%h row=%0d last=%b",
                                   oldest.chain_word, oldest.row_number, oldest.last,
                                   chain_word, row_number, last));
        end
      end
    end
  end

  // Hold the item until taken; otherwise present the next one or idle, and drive result_ready at random.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!item_valid || item_fire) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_item = pending_items.pop_front();
          item_valid <= 1'b1;
          func <= next_item.func;
          column_bits <= next_item.column_bits;
          cmd_addr <= next_item.cmd_addr;
          cmd_data <= next_item.cmd_data;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int directed_count;
    int run_len;
    int n;
    queue_item(FUNC_LOAD, 8'h00, 4'h0, 8'h00);
    queue_item(FUNC_LOAD, 8'hFF, 4'hF, 8'hFF);
    queue_item(FUNC_BCAST, 8'h00, 4'h0, 8'h00);
    queue_item(FUNC_BCAST, 8'hFF, 4'hF, 8'hFF);
    queue_item(FUNC_SHIFT, 8'h00, 4'h0, 8'h00);
    queue_item(FUNC_LOAD, 8'h81, 4'h3, 8'h12);
    queue_item(FUNC_SHIFT, 8'hFF, 4'hF, 8'hFF);
    queue_item(FUNC_LOAD, 8'hA5, 4'h0, 8'h00);
    queue_item(FUNC_SHIFT, 8'h00, 4'h0, 8'h00);
    queue_item(FUNC_LOAD, 8'h5A, 4'h0, 8'h00);
    queue_item(FUNC_SHIFT, 8'h00, 4'h0, 8'h00);
    queue_item(FUNC_SHIFT, 8'h00, 4'h0, 8'h00);
    queue_item(FUNC_LOAD, 8'h01, 4'h0, 8'h00);
    queue_item(FUNC_BCAST, 8'h00, 4'hA, 8'h5C);
    queue_item(FUNC_LOAD, 8'h80, 4'h0, 8'h00);
    queue_item(FUNC_BCAST, 8'h00, 4'h5, 8'hA3);
    queue_item(FUNC_CLEAR, 8'hFF, 4'hF, 8'hFF);
    queue_item(FUNC_CLEAR, 8'h00, 4'h0, 8'h00);
    queue_item(FUNC_LOAD, 8'h3C, 4'h0, 8'h00);
    queue_item(FUNC_SHIFT, 8'h00, 4'h0, 8'h00);
    queue_item(FUNC_CLEAR, 8'h00, 4'h0, 8'h00);
    directed_count = pending_items.size();

    // Mostly fill runs that walk columns across every device and past the top.
    while (pending_items.size() < directed_count + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 2) == 0) queue_random(FUNC_CLEAR);
        run_len = $urandom_range(10, 40);
        for (n = 0; n < run_len; n++) begin
          if ($urandom_range(0, 9) < 6) queue_random(FUNC_LOAD);
          if ($urandom_range(0, 9) == 0) queue_random(FUNC_BCAST);
          queue_random(FUNC_SHIFT);
        end
      end else begin
        run_len = $urandom_range(1, 8);
        for (n = 0; n < run_len; n++) queue_random(2'($urandom_range(0, 3)));
      end
    end
    // Trim the last run so the item count stays fixed.
    while (pending_items.size() > directed_count + RANDOM_ITEMS)
      void'(pending_items.pop_back());
    items_total = pending_items.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_taken != items_total) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d loads, %0d shifts, %0d clears, %0d broadcasts",
             items_taken, func_seen[FUNC_LOAD], func_seen[FUNC_SHIFT],
             func_seen[FUNC_CLEAR], func_seen[FUNC_BCAST]);
    $display("Checked %0d output beats over %0d cycles, %0d failures",
             beats_seen, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d of %0d items taken, %0d beats pending",
             items_taken, items_total, expected_beats.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
